// File: rtl/core/ltrc_pkg.sv
// shared types, constants and register codes of the lfo timer reload calculator
package ltrc_pkg;

  // default widths of the input fields
  localparam int SPEED_BITS_DEF    = 12;
  localparam int SYMMETRY_BITS_DEF = 10;

  // configuration field widths
  localparam int FREQ_W      = 10;
  localparam int CFG_SYM_W   = 10;
  localparam int GAIN_OFS_W  = 16;
  localparam int SHIFT_W     = 5;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;

  // datapath widths
  localparam int RELOAD_BITS = 7;
  localparam int COUNT_W     = 9;
  localparam int GAIN_W      = 17;
  localparam int PROD_W      = COUNT_W + GAIN_W;
  localparam int IDX_W       = 5;
  localparam int IDX_OUT_W   = 4;

  // arithmetic constants
  localparam int SC_SPLIT       = 127 - 12;
  localparam int RELOAD_OFFSET  = 12;
  localparam int SHORTEN_SLOPE  = 24;
  localparam int LENGTHEN_SLOPE = 3;
  localparam int FULL_COUNT     = 256;
  localparam int IDX_COMP_HI    = 8;
  localparam int IDX_COMP_LO    = 7;
  localparam int IDX_BASE_LOW   = 1;
  localparam int IDX_BASE_HIGH  = 2;
  localparam int IDX_CLAMP      = 16;
  localparam int IDX_OUT_MAX    = 15;

  // queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FREQUENCY_STEPS      = 4'd0,
    REG_SYMMETRY_ENABLE      = 4'd1,
    REG_SYMMETRY_HALF_SCALE  = 4'd2,
    REG_SYMMETRY_FULL_SCALE  = 4'd3,
    REG_SHORTEN_GAIN_OFFSET  = 4'd4,
    REG_SHORTEN_SHIFT        = 4'd5,
    REG_LENGTHEN_GAIN_OFFSET = 4'd6,
    REG_LENGTHEN_SHIFT       = 4'd7
  } ltrc_reg_t;

  // period adjustment class chosen by the front
  typedef enum logic [1:0] {
    OP_PASS  = 2'd0,
    OP_SHORT = 2'd1,
    OP_LONG  = 2'd2
  } ltrc_op_t;

  // configuration register set
  typedef struct packed {
    logic [FREQ_W-1:0]     frequency_steps;
    logic                  symmetry_enable;
    logic [CFG_SYM_W-1:0]  symmetry_half_scale;
    logic [CFG_SYM_W-1:0]  symmetry_full_scale;
    logic [GAIN_OFS_W-1:0] shorten_gain_offset;
    logic [SHIFT_W-1:0]    shorten_shift;
    logic [GAIN_OFS_W-1:0] lengthen_gain_offset;
    logic [SHIFT_W-1:0]    lengthen_shift;
  } ltrc_cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    ltrc_op_t           op;
    logic [COUNT_W-1:0] span;
    logic [GAIN_W-1:0]  gain;
    logic [IDX_W-1:0]   idx;
  } ltrc_entry_t;

endpackage

// File: rtl/core/ltrc_front.sv
// front part: speed scaling, reload split, symmetry fold and classification
module ltrc_front import ltrc_pkg::*; #(
  parameter int SPEED_BITS    = SPEED_BITS_DEF,
  parameter int SYMMETRY_BITS = SYMMETRY_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ltrc_cfg_t                cfg,
  input  logic                     accept,
  input  logic [SPEED_BITS-1:0]    speed_position,
  input  logic [SYMMETRY_BITS-1:0] symmetry_value,
  input  logic                     second_half,
  output logic                     push_valid,
  output ltrc_entry_t              push_entry
);

  localparam int PW = SPEED_BITS + FREQ_W;
  localparam int CW = (SYMMETRY_BITS > CFG_SYM_W) ? SYMMETRY_BITS : CFG_SYM_W;
  localparam int HW = SPEED_BITS - RELOAD_BITS;

  logic                     valid_r;
  logic [PW-1:0]            prod_r, prod_nxt;
  logic [SYMMETRY_BITS-1:0] sym_r;
  logic                     second_r;

  logic [SPEED_BITS-1:0]    sc, s_hi;
  logic [HW-1:0]            hi_q;
  logic [15:0]              hi_ext;
  logic [RELOAD_BITS-1:0]   reload;
  logic [IDX_W-1:0]         idx;
  logic [CW-1:0]            sym_x, half_x, full_x, folded;
  logic [CFG_SYM_W-1:0]     sym_eff;
  logic                     above, off_half, shorten;
  logic [GAIN_OFS_W-1:0]    three_x, gain_long;
  logic [GAIN_W-1:0]        gain_short;

  // speed scaling multiply, registered
  assign prod_nxt = PW'(speed_position) * PW'(cfg.frequency_steps);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_r   <= prod_nxt;
      sym_r    <= symmetry_value;
      second_r <= second_half;
    end
  end

  // split scaled speed into reload and base prescaler index
  always_comb begin
    sc     = prod_r[PW-1 -: SPEED_BITS];
    s_hi   = sc - SPEED_BITS'(SC_SPLIT);
    hi_q   = s_hi[SPEED_BITS-1:RELOAD_BITS];
    hi_ext = 16'(hi_q);
    if (sc <= SPEED_BITS'(SC_SPLIT)) begin
      reload = RELOAD_BITS'(sc[RELOAD_BITS-1:0] + RELOAD_BITS'(RELOAD_OFFSET));
      idx    = IDX_W'(IDX_BASE_LOW);
    end else begin
      reload = s_hi[RELOAD_BITS-1:0];
      // indexes past the table all behave alike, so clamp
      if (hi_ext >= 16'(IDX_CLAMP - IDX_BASE_HIGH)) begin
        idx = IDX_W'(IDX_CLAMP);
      end else begin
        idx = IDX_W'(hi_ext[3:0]) + IDX_W'(IDX_BASE_HIGH);
      end
    end
  end

  // symmetry fold about half scale
  always_comb begin
    sym_x    = CW'(sym_r);
    half_x   = CW'(cfg.symmetry_half_scale);
    full_x   = CW'(cfg.symmetry_full_scale);
    above    = sym_x > half_x;
    off_half = sym_x != half_x;
    folded   = (full_x >= sym_x) ? (full_x - sym_x) : '0;
    sym_eff  = above ? folded[CFG_SYM_W-1:0] : sym_x[CFG_SYM_W-1:0];
    shorten  = second_r ? above : !above;
  end

  // linear gain terms for both directions
  always_comb begin
    gain_short = GAIN_W'(cfg.shorten_gain_offset)
               + GAIN_W'(sym_eff) * GAIN_W'(SHORTEN_SLOPE);
    three_x    = GAIN_OFS_W'(sym_eff) * GAIN_OFS_W'(LENGTHEN_SLOPE);
    gain_long  = (cfg.lengthen_gain_offset > three_x) ?
                 (cfg.lengthen_gain_offset - three_x) : '0;
  end

  // classified entry towards the queue
  always_comb begin
    push_valid      = valid_r;
    push_entry.span = COUNT_W'(FULL_COUNT) - COUNT_W'(reload);
    push_entry.idx  = idx;
    if (!cfg.symmetry_enable || !off_half) begin
      push_entry.op   = OP_PASS;
      push_entry.gain = '0;
    end else if (shorten) begin
      push_entry.op   = OP_SHORT;
      push_entry.gain = gain_short;
    end else begin
      push_entry.op   = OP_LONG;
      push_entry.gain = GAIN_W'(gain_long);
    end
  end

endmodule

// File: rtl/core/ltrc_queue.sv
// short fifo between the front and the back part
module ltrc_queue import ltrc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  ltrc_entry_t              push_entry,
  input  logic                     pop,
  output ltrc_entry_t              pop_entry,
  output logic                     empty,
  output logic [$clog2(DEPTH):0]   count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ltrc_entry_t            mem [DEPTH];
  logic [AW-1:0]          wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]          rd_ptr_r, rd_ptr_nxt;
  logic [$clog2(DEPTH):0] count_r, count_nxt;
  logic                   do_pop;

  assign do_pop = pop && (count_r != '0);

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  assign pop_entry = mem[rd_ptr_r];
  assign empty     = (count_r == '0);
  assign count     = count_r;

endmodule

// File: rtl/core/ltrc_back.sv
// back part: gain multiply, shift, clamp and latency compensation
module ltrc_back import ltrc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ltrc_cfg_t            cfg,
  input  logic                 entry_valid,
  input  ltrc_entry_t          entry,
  output logic                 entry_pop,
  output logic                 out_strobe,
  output logic [COUNT_W-1:0]   out_timer_reload,
  output logic [IDX_OUT_W-1:0] out_prescaler_index,
  output logic                 out_prescaler_doubled
);

  logic                 valid_r;
  ltrc_op_t             op_r;
  logic [COUNT_W-1:0]   span_r;
  logic [IDX_W-1:0]     idx_r;
  logic [PROD_W-1:0]    prod_r, prod_nxt;

  logic [PROD_W-1:0]    d_raw, d_half;
  logic [COUNT_W-1:0]   d_fin, fin, fin_comp;
  logic [IDX_W-1:0]     idx_fin;
  logic                 doubled;

  logic                 strobe_r;
  logic [COUNT_W-1:0]   reload_r, reload_nxt;
  logic [IDX_OUT_W-1:0] index_r, index_nxt;
  logic                 doubled_r;

  // the back never stalls, so take an entry whenever one waits
  assign entry_pop = entry_valid;
  assign prod_nxt  = PROD_W'(entry.span) * PROD_W'(entry.gain);

  // multiply stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= entry_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (entry_valid) begin
      prod_r <= prod_nxt;
      op_r   <= entry.op;
      span_r <= entry.span;
      idx_r  <= entry.idx;
    end
  end

  // shift and clamp of the period change
  always_comb begin
    d_raw   = '0;
    d_half  = '0;
    d_fin   = '0;
    idx_fin = idx_r;
    doubled = 1'b0;
    fin     = COUNT_W'(FULL_COUNT) - span_r;
    case (op_r)
      OP_PASS: begin
        fin = COUNT_W'(FULL_COUNT) - span_r;
      end
      OP_SHORT: begin
        d_raw = prod_r >> cfg.shorten_shift;
        d_fin = (d_raw > PROD_W'(FULL_COUNT)) ? COUNT_W'(FULL_COUNT) : d_raw[COUNT_W-1:0];
        fin   = COUNT_W'(FULL_COUNT) - d_fin;
      end
      OP_LONG: begin
        d_raw = prod_r >> cfg.lengthen_shift;
        if (d_raw > PROD_W'(FULL_COUNT)) begin
          // halve the count and step the prescaler down
          d_half  = d_raw >> 1;
          d_fin   = (d_half > PROD_W'(FULL_COUNT)) ?
                    COUNT_W'(FULL_COUNT) : d_half[COUNT_W-1:0];
          idx_fin = idx_r - 1'b1;
          doubled = 1'b1;
        end else begin
          d_fin = d_raw[COUNT_W-1:0];
        end
        fin = COUNT_W'(FULL_COUNT) - d_fin;
      end
      default: begin
        fin = COUNT_W'(FULL_COUNT) - span_r;
      end
    endcase
  end

  // update latency compensation and index saturation
  always_comb begin
    fin_comp = fin;
    if (cfg.symmetry_enable) begin
      if (idx_fin == IDX_W'(IDX_COMP_HI)) begin
        fin_comp = fin + COUNT_W'(2);
      end else if (idx_fin == IDX_W'(IDX_COMP_LO)) begin
        fin_comp = fin + COUNT_W'(1);
      end
    end
    reload_nxt = fin_comp;
    index_nxt  = (idx_fin > IDX_W'(IDX_OUT_MAX)) ?
                 IDX_OUT_W'(IDX_OUT_MAX) : idx_fin[IDX_OUT_W-1:0];
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_r) begin
      reload_r  <= reload_nxt;
      index_r   <= index_nxt;
      doubled_r <= doubled;
    end
  end

  assign out_strobe            = strobe_r;
  assign out_timer_reload      = reload_r;
  assign out_prescaler_index   = index_r;
  assign out_prescaler_doubled = doubled_r;

endmodule

// File: rtl/core/lfo_timer_reload_calc.sv
// top level of the lfo timer reload calculator
//
// Input channel: an item (speed position, symmetry value, half-cycle flag)
// is taken at a rising edge where start is high and busy is low. One result
// follows each item: timer reload, prescaler index and a flag that the
// lengthening path halved the count.
// Result channel: out_strobe is high for exactly one cycle with the result;
// the receiver cannot hold it off, so results leave as soon as they are made.
// Path: an accepted item passes the scaling multiply register, the queue,
// the gain multiply register and the output register before its result
// reaches the ports.
// Throughput: one item per cycle; busy rises only when the front-to-back
// queue plus the item in the front stage would fill the queue.
// Configuration: eight registers written through cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high. Write only while no
// item is in flight.
// Reset: synchronous active-low rst_n clears the pipeline, empties the queue
// and loads the register defaults. No clearing pass is needed.
module lfo_timer_reload_calc import ltrc_pkg::*; #(
  parameter int SPEED_BITS    = SPEED_BITS_DEF,
  parameter int SYMMETRY_BITS = SYMMETRY_BITS_DEF,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [SPEED_BITS-1:0]    in_speed_position,
  input  logic [SYMMETRY_BITS-1:0] in_symmetry_value,
  input  logic                     in_second_half,
  output logic                     out_strobe,
  output logic [COUNT_W-1:0]       out_timer_reload,
  output logic [IDX_OUT_W-1:0]     out_prescaler_index,
  output logic                     out_prescaler_doubled,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  localparam int QCW = $clog2(QUEUE_DEPTH) + 1;

  ltrc_cfg_t       cfg_r;
  logic            accept;
  logic            push_valid;
  ltrc_entry_t     push_entry;
  ltrc_entry_t     pop_entry;
  logic            pop;
  logic            q_empty;
  logic [QCW-1:0]  q_count;
  logic [QCW:0]    occupancy;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frequency_steps      <= FREQ_W'(600);
      cfg_r.symmetry_enable      <= 1'b1;
      cfg_r.symmetry_half_scale  <= CFG_SYM_W'(128);
      cfg_r.symmetry_full_scale  <= CFG_SYM_W'(255);
      cfg_r.shorten_gain_offset  <= GAIN_OFS_W'(1024);
      cfg_r.shorten_shift        <= SHIFT_W'(12);
      cfg_r.lengthen_gain_offset <= GAIN_OFS_W'(1024);
      cfg_r.lengthen_shift       <= SHIFT_W'(9);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FREQUENCY_STEPS:      cfg_r.frequency_steps      <= cfg_data[FREQ_W-1:0];
        REG_SYMMETRY_ENABLE:      cfg_r.symmetry_enable      <= cfg_data[0];
        REG_SYMMETRY_HALF_SCALE:  cfg_r.symmetry_half_scale  <= cfg_data[CFG_SYM_W-1:0];
        REG_SYMMETRY_FULL_SCALE:  cfg_r.symmetry_full_scale  <= cfg_data[CFG_SYM_W-1:0];
        REG_SHORTEN_GAIN_OFFSET:  cfg_r.shorten_gain_offset  <= cfg_data[GAIN_OFS_W-1:0];
        REG_SHORTEN_SHIFT:        cfg_r.shorten_shift        <= cfg_data[SHIFT_W-1:0];
        REG_LENGTHEN_GAIN_OFFSET: cfg_r.lengthen_gain_offset <= cfg_data[GAIN_OFS_W-1:0];
        REG_LENGTHEN_SHIFT:       cfg_r.lengthen_shift       <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // hold off new items when the queue could not take them
  assign occupancy = (QCW+1)'(q_count) + (QCW+1)'(push_valid);
  assign busy      = occupancy >= (QCW+1)'(QUEUE_DEPTH);
  assign accept    = start && !busy;

  ltrc_front #(
    .SPEED_BITS    (SPEED_BITS),
    .SYMMETRY_BITS (SYMMETRY_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .accept         (accept),
    .speed_position (in_speed_position),
    .symmetry_value (in_symmetry_value),
    .second_half    (in_second_half),
    .push_valid     (push_valid),
    .push_entry     (push_entry)
  );

  ltrc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .empty      (q_empty),
    .count      (q_count)
  );

  ltrc_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg_r),
    .entry_valid           (!q_empty),
    .entry                 (pop_entry),
    .entry_pop             (pop),
    .out_strobe            (out_strobe),
    .out_timer_reload      (out_timer_reload),
    .out_prescaler_index   (out_prescaler_index),
    .out_prescaler_doubled (out_prescaler_doubled)
  );

endmodule

// File: rtl/core/ltrc_checker.sv
// port-level checks of the lfo timer reload calculator, bound to the top level
module ltrc_checker import ltrc_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_strobe,
  input logic [COUNT_W-1:0] out_timer_reload
);

  // every accepted transfer yields a result
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_strobe)
    else $error("accepted item gave no result");

  // no result without a matching accepted transfer
  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 4))
    else $error("result without accepted item");

  // reset empties the pipeline
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result right after reset");

  // reload never exceeds full count plus compensation
  a_reload_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_timer_reload <= COUNT_W'(FULL_COUNT + 2)))
    else $error("timer reload out of range");

endmodule

bind lfo_timer_reload_calc ltrc_checker u_ltrc_checker (.*);

// File: bench/lfo_timer_reload_calc_tb.sv
// self-checking testbench of the lfo timer reload calculator
module lfo_timer_reload_calc_tb import ltrc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SPEED_W       = 12;
  localparam int SYM_W         = 10;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 216;
  localparam int NUM_PHASES    = 8;

  // constants of the reload arithmetic
  localparam int unsigned SPLIT_POINT  = 115;
  localparam int unsigned LOW_OFFSET   = 12;
  localparam int unsigned SHORT_SLOPE  = 24;
  localparam int unsigned LONG_SLOPE   = 3;
  localparam int unsigned FULL_SPAN    = 256;
  localparam int unsigned COMP_IDX_TWO = 8;
  localparam int unsigned COMP_IDX_ONE = 7;
  localparam int unsigned MAX_INDEX    = 15;

  typedef struct {
    logic [COUNT_W-1:0]   timer_reload;
    logic [IDX_OUT_W-1:0] prescaler_index;
    logic                 prescaler_doubled;
  } reload_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [SPEED_W-1:0]     in_speed_position = '0;
  logic [SYM_W-1:0]       in_symmetry_value = '0;
  logic                   in_second_half = 1'b0;
  logic                   out_strobe;
  logic [COUNT_W-1:0]     out_timer_reload;
  logic [IDX_OUT_W-1:0]   out_prescaler_index;
  logic                   out_prescaler_doubled;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  ltrc_reg_t              cfg_index = REG_FREQUENCY_STEPS;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  ltrc_cfg_t              cur_cfg;
  reload_result_t         pending_reloads[$];
  int                     mismatches = 0;
  int                     sender_idle_pct = 0;

  lfo_timer_reload_calc u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_speed_position     (in_speed_position),
    .in_symmetry_value     (in_symmetry_value),
    .in_second_half        (in_second_half),
    .out_strobe            (out_strobe),
    .out_timer_reload      (out_timer_reload),
    .out_prescaler_index   (out_prescaler_index),
    .out_prescaler_doubled (out_prescaler_doubled),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  always #2 clk = ~clk;

  // reload, prescaler index and doubling flag for one control update
  function automatic reload_result_t predict_reload(input ltrc_cfg_t c,
                                                    input logic [SPEED_W-1:0] speed,
                                                    input logic [SYM_W-1:0] sym_in,
                                                    input logic second_half);
    int unsigned scaled, reload, idx, fin, span, sym, gain, delta;
    logic cw, shorten, doubled;
    reload_result_t r;
    scaled  = (32'(speed) * 32'(c.frequency_steps)) >> 10;
    sym     = 32'(sym_in);
    doubled = 1'b0;
    if (scaled <= SPLIT_POINT) begin
      reload = scaled + LOW_OFFSET;
      idx    = 1;
    end else begin
      reload = (scaled - SPLIT_POINT) & 32'd127;
      idx    = ((scaled - SPLIT_POINT) >> 7) + 2;
    end
    fin = reload;
    if (c.symmetry_enable) begin
      if (sym != 32'(c.symmetry_half_scale)) begin
        cw   = 1'b0;
        span = FULL_SPAN - reload;
        // fold values above half scale, never below zero
        if (sym > 32'(c.symmetry_half_scale)) begin
          sym = (32'(c.symmetry_full_scale) >= sym) ? 32'(c.symmetry_full_scale) - sym : 0;
          cw  = 1'b1;
        end
        shorten = second_half ? cw : !cw;
        if (shorten) begin
          delta = (span * (32'(c.shorten_gain_offset) + SHORT_SLOPE * sym)) >> c.shorten_shift;
          if (delta > FULL_SPAN) delta = FULL_SPAN;
        end else begin
          gain = (32'(c.lengthen_gain_offset) > LONG_SLOPE * sym) ?
                 32'(c.lengthen_gain_offset) - LONG_SLOPE * sym : 0;
          delta = (span * gain) >> c.lengthen_shift;
          // long count: halve it and step the prescaler down
          if (delta > FULL_SPAN) begin
            delta = delta >> 1;
            if (delta > FULL_SPAN) delta = FULL_SPAN;
            idx     = idx - 1;
            doubled = 1'b1;
          end
        end
        fin = FULL_SPAN - delta;
      end
      // update latency compensation on the unsaturated index
      if (idx == COMP_IDX_TWO) fin = fin + 2;
      else if (idx == COMP_IDX_ONE) fin = fin + 1;
    end
    r.timer_reload      = fin[COUNT_W-1:0];
    r.prescaler_index   = (idx > MAX_INDEX) ? IDX_OUT_W'(MAX_INDEX) : idx[IDX_OUT_W-1:0];
    r.prescaler_doubled = doubled;
    return r;
  endfunction

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin : check_results
    reload_result_t want;
    if (rst_n && out_strobe) begin
      if (pending_reloads.size() == 0) begin
        $error("result with nothing expected: reload %0d index %0d doubled %0d",
               out_timer_reload, out_prescaler_index, out_prescaler_doubled);
        mismatches++;
      end else begin
        want = pending_reloads.pop_front();
        if (out_timer_reload !== want.timer_reload) begin
          $error("timer_reload expected %0d got %0d", want.timer_reload, out_timer_reload);
          mismatches++;
        end
        if (out_prescaler_index !== want.prescaler_index) begin
          $error("prescaler_index expected %0d got %0d",
                 want.prescaler_index, out_prescaler_index);
          mismatches++;
        end
        if (out_prescaler_doubled !== want.prescaler_doubled) begin
          $error("prescaler_doubled expected %0d got %0d",
                 want.prescaler_doubled, out_prescaler_doubled);
          mismatches++;
        end
      end
    end
  end

  // one control update, with random idle cycles ahead of it
  task automatic send_item(input logic [SPEED_W-1:0] speed, input logic [SYM_W-1:0] sym,
                           input logic second_half);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start             <= 1'b1;
    in_speed_position <= speed;
    in_symmetry_value <= sym;
    in_second_half    <= second_half;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_reloads.push_back(predict_reload(cur_cfg, speed, sym, second_half));
  endtask

  // stop sending and let every expected result arrive
  task automatic wait_drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_reloads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input ltrc_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    case (idx)
      REG_FREQUENCY_STEPS:      cur_cfg.frequency_steps      = value[FREQ_W-1:0];
      REG_SYMMETRY_ENABLE:      cur_cfg.symmetry_enable      = value[0];
      REG_SYMMETRY_HALF_SCALE:  cur_cfg.symmetry_half_scale  = value[CFG_SYM_W-1:0];
      REG_SYMMETRY_FULL_SCALE:  cur_cfg.symmetry_full_scale  = value[CFG_SYM_W-1:0];
      REG_SHORTEN_GAIN_OFFSET:  cur_cfg.shorten_gain_offset  = value[GAIN_OFS_W-1:0];
      REG_SHORTEN_SHIFT:        cur_cfg.shorten_shift        = value[SHIFT_W-1:0];
      REG_LENGTHEN_GAIN_OFFSET: cur_cfg.lengthen_gain_offset = value[GAIN_OFS_W-1:0];
      REG_LENGTHEN_SHIFT:       cur_cfg.lengthen_shift       = value[SHIFT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_config(input ltrc_cfg_t c);
    cfg_write(REG_FREQUENCY_STEPS,      CFG_DATA_W'(c.frequency_steps));
    cfg_write(REG_SYMMETRY_ENABLE,      CFG_DATA_W'(c.symmetry_enable));
    cfg_write(REG_SYMMETRY_HALF_SCALE,  CFG_DATA_W'(c.symmetry_half_scale));
    cfg_write(REG_SYMMETRY_FULL_SCALE,  CFG_DATA_W'(c.symmetry_full_scale));
    cfg_write(REG_SHORTEN_GAIN_OFFSET,  CFG_DATA_W'(c.shorten_gain_offset));
    cfg_write(REG_SHORTEN_SHIFT,        CFG_DATA_W'(c.shorten_shift));
    cfg_write(REG_LENGTHEN_GAIN_OFFSET, CFG_DATA_W'(c.lengthen_gain_offset));
    cfg_write(REG_LENGTHEN_SHIFT,       CFG_DATA_W'(c.lengthen_shift));
  endtask

  function automatic ltrc_cfg_t default_settings();
    ltrc_cfg_t c;
    c.frequency_steps      = 10'd600;
    c.symmetry_enable      = 1'b1;
    c.symmetry_half_scale  = 10'd128;
    c.symmetry_full_scale  = 10'd255;
    c.shorten_gain_offset  = 16'd1024;
    c.shorten_shift        = 5'd12;
    c.lengthen_gain_offset = 16'd1024;
    c.lengthen_shift       = 5'd9;
    return c;
  endfunction

  // random settings, mostly in a range that gives varied reload counts
  function automatic ltrc_cfg_t random_settings();
    ltrc_cfg_t c;
    c.frequency_steps      = FREQ_W'($urandom_range(1023, 1));
    c.symmetry_enable      = ($urandom_range(7) != 0);
    c.symmetry_half_scale  = CFG_SYM_W'($urandom_range(1023));
    c.symmetry_full_scale  = CFG_SYM_W'($urandom_range(1023));
    c.shorten_gain_offset  = ($urandom_range(3) == 0) ? GAIN_OFS_W'($urandom_range(65535))
                                                      : GAIN_OFS_W'($urandom_range(4096, 256));
    c.lengthen_gain_offset = ($urandom_range(3) == 0) ? GAIN_OFS_W'($urandom_range(65535))
                                                      : GAIN_OFS_W'($urandom_range(4096, 256));
    c.shorten_shift        = ($urandom_range(3) == 0) ? SHIFT_W'($urandom_range(31))
                                                      : SHIFT_W'($urandom_range(14, 8));
    c.lengthen_shift       = ($urandom_range(3) == 0) ? SHIFT_W'($urandom_range(31))
                                                      : SHIFT_W'($urandom_range(12, 6));
    return c;
  endfunction

  // symmetry values clustered at and around half scale, else anywhere
  function automatic logic [SYM_W-1:0] random_symmetry();
    int pick;
    int val;
    pick = $urandom_range(99);
    val  = int'(cur_cfg.symmetry_half_scale);
    if (pick < 10) return SYM_W'(val);
    if (pick < 25) begin
      val = val + int'($urandom_range(6)) - 3;
      if (val < 0) val = 0;
      if (val > 1023) val = 1023;
      return SYM_W'(val);
    end
    return SYM_W'($urandom_range(1023));
  endfunction

  // extremes and index boundaries with the settings out of reset
  task automatic test_reset_defaults();
    sender_idle_pct = 0;
    send_item(12'd0,    10'd0,    1'b0);
    send_item(12'd0,    10'd0,    1'b1);
    send_item(12'd4095, 10'd1023, 1'b0);
    send_item(12'd4095, 10'd1023, 1'b1);
    send_item(12'd2000, 10'd128,  1'b0);
    send_item(12'd2000, 10'd128,  1'b1);
    send_item(12'd1396, 10'd100,  1'b0);
    send_item(12'd1621, 10'd200,  1'b1);
    send_item(12'd1834, 10'd0,    1'b1);
    send_item(12'd196,  10'd127,  1'b1);
    send_item(12'd197,  10'd129,  1'b0);
    send_item(12'd198,  10'd129,  1'b1);
    wait_drain();
  endtask

  // raw reload and base index pass straight through
  task automatic test_symmetry_disabled();
    cfg_write(REG_SYMMETRY_ENABLE, '0);
    send_item(12'd4095, 10'd1023, 1'b1);
    send_item(12'd1621, 10'd0,    1'b0);
    send_item(12'd0,    10'd128,  1'b1);
    wait_drain();
  endtask

  // negative lengthen gain, shortened clamp, halved count still too long
  task automatic test_clamp_paths();
    ltrc_cfg_t c;
    c = default_settings();
    c.symmetry_half_scale = 10'd1023;
    c.shorten_shift       = 5'd0;
    c.lengthen_shift      = 5'd0;
    apply_config(c);
    send_item(12'd1000, 10'd500,  1'b1);
    send_item(12'd1000, 10'd1000, 1'b1);
    send_item(12'd1000, 10'd0,    1'b0);
    send_item(12'd1834, 10'd0,    1'b1);
    send_item(12'd4095, 10'd0,    1'b1);
    wait_drain();
  endtask

  // random traffic through several settings and idle profiles
  task automatic test_random_traffic();
    int idle_profile[4] = '{0, 61, 0, 37};
    ltrc_cfg_t c;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase == 0) begin
        c = default_settings();
      end else if (phase == 1) begin
        c = '{frequency_steps: 10'd1023, symmetry_enable: 1'b1,
              symmetry_half_scale: 10'd1023, symmetry_full_scale: 10'd1023,
              shorten_gain_offset: 16'hffff, shorten_shift: 5'd31,
              lengthen_gain_offset: 16'hffff, lengthen_shift: 5'd31};
      end else if (phase == 2) begin
        c = '{frequency_steps: 10'd1, symmetry_enable: 1'b1,
              symmetry_half_scale: 10'd0, symmetry_full_scale: 10'd0,
              shorten_gain_offset: 16'd0, shorten_shift: 5'd0,
              lengthen_gain_offset: 16'd0, lengthen_shift: 5'd0};
      end else begin
        c = random_settings();
      end
      apply_config(c);
      sender_idle_pct = idle_profile[phase % 4];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold off now and then until every result is back
        if (n == PHASE_ITEMS / 2 || $urandom_range(63) == 0) wait_drain();
        send_item(SPEED_W'($urandom_range(4095)), random_symmetry(), 1'($urandom_range(1)));
      end
      wait_drain();
    end
  endtask

  // run limit
  initial begin
    #2000000;
    $display("lfo_timer_reload_calc_tb: FAIL");
    $finish;
  end

  initial begin
    cur_cfg = default_settings();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_symmetry_disabled();
    test_clamp_paths();
    test_random_traffic();

    wait_drain();
    if (pending_reloads.size() != 0) begin
      $error("%0d expected results never arrived", pending_reloads.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("lfo_timer_reload_calc_tb: PASS");
    end else begin
      $display("lfo_timer_reload_calc_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/ltrc_pkg.sv
rtl/core/ltrc_front.sv
rtl/core/ltrc_queue.sv
rtl/core/ltrc_back.sv
rtl/core/lfo_timer_reload_calc.sv
rtl/core/ltrc_checker.sv
bench/lfo_timer_reload_calc_tb.sv
